// ===== rtl/core/ptsl_pkg.sv =====
// shared types, constants and yaw helpers for the pose target slew limiter
package ptsl_pkg;

   // field widths fixed by the item format
   localparam int YAW_W     = 31;
   localparam int TSTEP_W   = 31;
   localparam int YSTEP_W   = 30;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 31;

   // opcodes
   localparam logic [1:0] OP_BLEND = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TSTEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YSTEP = 1'd1;

   // fixed-point constants, Q3.28 yaw and Q16.16 position
   localparam logic signed [32:0] PI_Q      = 33'sd843314857;
   localparam logic signed [32:0] TWO_PI_Q  = 33'sd1686629713;
   localparam logic signed [32:0] YAW_EPS_Q = 33'sd268;
   localparam logic signed [32:0] YAW_TOL_Q = 33'sd268435;
   localparam logic [6:0]         POS_TOL_Q = 7'd65;

   // iteration counts of the shared unit
   localparam int SQRT_STEPS = 32;

   typedef enum logic [3:0] {
      ALU_IDLE,
      ALU_LOAD,
      ALU_NORM,
      ALU_SQX,
      ALU_SQY,
      ALU_SQRT_INIT,
      ALU_SQRT,
      ALU_LEN,
      ALU_MUL_INIT,
      ALU_MUL,
      ALU_DIV_INIT,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       axis_y;
   } alu_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_NORM,
      ST_SQX,
      ST_SQY,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_LEN,
      ST_CHECK,
      ST_MUL_INIT,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_APPLY,
      ST_YAW,
      ST_DONE
   } state_type;

   // one wrap into minus pi to pi, enough for sums of two in-range angles
   function automatic logic signed [32:0] wrap_yaw(input logic signed [32:0] a);
      logic signed [32:0] r;
      r = a;
      if (a > PI_Q) begin
         r = a - TWO_PI_Q;
      end else if (a < -PI_Q) begin
         r = a + TWO_PI_Q;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ptsl_if.sv =====
// request and response channel interfaces of the pose target slew limiter
interface ptsl_req_if #(parameter int CW = 32);
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic signed [CW-1:0]                 pose_x;
   logic signed [CW-1:0]                 pose_y;
   logic signed [ptsl_pkg::YAW_W-1:0]    pose_yaw;
   logic                                 pose_valid;
   logic                                 tracking;

   modport source (output valid, opcode, pose_x, pose_y, pose_yaw, pose_valid, tracking,
                   input ready);
   modport sink   (input valid, opcode, pose_x, pose_y, pose_yaw, pose_valid, tracking,
                   output ready);
endinterface

interface ptsl_rsp_if #(parameter int CW = 32);
   logic                                 valid;
   logic                                 ready;
   logic signed [CW-1:0]                 out_x;
   logic signed [CW-1:0]                 out_y;
   logic signed [ptsl_pkg::YAW_W-1:0]    out_yaw;
   logic                                 out_valid;
   logic                                 blending_active;

   modport source (output valid, out_x, out_y, out_yaw, out_valid, blending_active,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_yaw, out_valid, blending_active,
                   output ready);
endinterface

// ===== rtl/core/pose_target_slew_limiter_top.sv =====
// top level of the pose target slew limiter: sequencer, target state and result register
//
// Holds one pending planar target pose and steps a stream of current poses
// toward it. The req_ch channel carries one request per item: opcode set
// target, clear target or blend, plus a pose and the tracking flag. Only a
// blend request yields a response on rsp_ch. The csr_ port writes the
// translation step limit (index 0) and the yaw step limit (index 1).
// The block takes one request at a time: req_ch.ready is high only while the
// sequencer is idle. Set and clear complete in the idle state, and a blend that
// passes straight through goes to the response state. A stepped blend runs a
// shared root, multiply and divide unit: normalize shifts, squares and a root
// for each of the two error lengths, then per axis a 31-step multiply and a
// COORD_WIDTH+32-step divide, then the yaw step and the response; a blend
// that snaps to the target skips the multiply and divide.
// The response sits in an output register; a stalled receiver holds it,
// and a finished blend waits in the last state until that register frees.
// Synchronous reset clears the target, the pending flag, both step
// registers and the response valid.
module pose_target_slew_limiter_top #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ptsl_req_if.sink                              req_ch,
   ptsl_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [ptsl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptsl_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int LW   = (CW + 1 > 64) ? 64 : CW + 1;
   localparam int MW   = CW + 1 + ptsl_pkg::TSTEP_W;
   localparam int CNTW = $clog2(MW + 1);
   localparam int YW   = ptsl_pkg::YAW_W;

   ptsl_pkg::state_type   state_ff, state_in;
   ptsl_pkg::alu_cmd_type cmd;
   logic [CNTW-1:0]       cnt_ff, cnt_in;

   logic [ptsl_pkg::TSTEP_W-1:0] tstep_ff;
   logic [ptsl_pkg::YSTEP_W-1:0] ystep_ff;
   logic signed [CW-1:0] tx_ff, ty_ff, cx_ff, cy_ff, ox_ff, oy_ff;
   logic signed [YW-1:0] tyaw_ff, cyaw_ff, oyaw_ff;
   logic                 pend_ff, track_ff, phase_ff, axis_ff, sx_ff, sy_ff, ovalid_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic signed [YW-1:0] rsp_yaw_ff;
   logic                 rsp_ovalid_ff, rsp_active_ff, rsp_valid_ff;

   logic                 req_fire, rsp_free, norm_done;
   logic [LW-1:0]        len;
   logic [MW-1:0]        acc;

   logic signed [CW-1:0] dsrc_x, dsrc_y;
   logic signed [CW:0]   dx, dy;
   logic [CW:0]          mag_x, mag_y;
   logic                 step_take;
   logic                 settle;

   logic signed [32:0]   tyaw_s, cyaw_s, oyaw_s, ysl, dyaw, yclamp, oyaw_new, remy, remy_abs;
   logic                 yaw_move;
   logic signed [CW-1:0] app_base, app_res;
   logic [CW-1:0]        mv;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ptsl_pkg::ST_IDLE);

   // error vector toward the target, saturated only at 64-bit or wider coordinates
   function automatic logic signed [CW:0] sat_diff(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
      logic signed [CW:0] r;
      logic               s;
      r = {a[CW-1], a} - {b[CW-1], b};
      s = r[CW];
      if (CW >= 64 && (r[CW] != r[CW-1])) begin
         r = {s, s, {(CW-1){~s}}};
      end
      return r;
   endfunction

   assign dsrc_x = phase_ff ? ox_ff : cx_ff;
   assign dsrc_y = phase_ff ? oy_ff : cy_ff;
   assign dx     = sat_diff(tx_ff, dsrc_x);
   assign dy     = sat_diff(ty_ff, dsrc_y);
   assign mag_x  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
   assign mag_y  = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);

   // length checks
   assign step_take = (len != '0) && (tstep_ff != '0) &&
                      ((LW+ptsl_pkg::TSTEP_W)'(tstep_ff) < (LW+ptsl_pkg::TSTEP_W)'(len));

   // yaw step, clamped and wrapped
   always_comb begin
      tyaw_s   = 33'(tyaw_ff);
      cyaw_s   = 33'(cyaw_ff);
      oyaw_s   = 33'(oyaw_ff);
      ysl      = $signed({3'b000, ystep_ff});
      dyaw     = ptsl_pkg::wrap_yaw(tyaw_s - cyaw_s);
      yaw_move = (dyaw > ptsl_pkg::YAW_EPS_Q || dyaw < -ptsl_pkg::YAW_EPS_Q) &&
                 (ystep_ff != '0);
      if (dyaw > ysl) begin
         yclamp = ysl;
      end else if (dyaw < -ysl) begin
         yclamp = -ysl;
      end else begin
         yclamp = dyaw;
      end
      oyaw_new = yaw_move ? ptsl_pkg::wrap_yaw(cyaw_s + yclamp) : tyaw_s;
      remy     = ptsl_pkg::wrap_yaw(tyaw_s - oyaw_s);
      remy_abs = (remy < 0) ? -remy : remy;
   end

   assign settle = (len <= LW'(ptsl_pkg::POS_TOL_Q)) &&
                   (remy_abs <= ptsl_pkg::YAW_TOL_Q) && track_ff;

   // apply the scaled move on one axis
   assign mv       = acc[CW-1:0];
   assign app_base = axis_ff ? cy_ff : cx_ff;
   assign app_res  = (axis_ff ? sy_ff : sx_ff) ? app_base - $signed(mv)
                                               : app_base + $signed(mv);

   ptsl_arith #(.CW(CW)) u_arith (
      .clock       (clock),
      .cmd         (cmd),
      .mag_x_i     (mag_x),
      .mag_y_i     (mag_y),
      .step_i      (tstep_ff),
      .norm_done_o (norm_done),
      .len_o       (len),
      .acc_o       (acc)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptsl_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and unit commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.op     = ptsl_pkg::ALU_IDLE;
      cmd.axis_y = axis_ff;
      case (state_ff)
         ptsl_pkg::ST_IDLE: begin
            if (req_fire && req_ch.opcode == ptsl_pkg::OP_BLEND) begin
               if (!pend_ff || !req_ch.pose_valid) begin
                  state_in = ptsl_pkg::ST_DONE;
               end else begin
                  state_in = ptsl_pkg::ST_LOAD;
               end
            end
         end
         ptsl_pkg::ST_LOAD: begin
            cmd.op   = ptsl_pkg::ALU_LOAD;
            state_in = ptsl_pkg::ST_NORM;
         end
         ptsl_pkg::ST_NORM: begin
            if (norm_done) begin
               state_in = ptsl_pkg::ST_SQX;
            end else begin
               cmd.op = ptsl_pkg::ALU_NORM;
            end
         end
         ptsl_pkg::ST_SQX: begin
            cmd.op   = ptsl_pkg::ALU_SQX;
            state_in = ptsl_pkg::ST_SQY;
         end
         ptsl_pkg::ST_SQY: begin
            cmd.op   = ptsl_pkg::ALU_SQY;
            state_in = ptsl_pkg::ST_SQRT_INIT;
         end
         ptsl_pkg::ST_SQRT_INIT: begin
            cmd.op   = ptsl_pkg::ALU_SQRT_INIT;
            cnt_in   = CNTW'(ptsl_pkg::SQRT_STEPS - 1);
            state_in = ptsl_pkg::ST_SQRT;
         end
         ptsl_pkg::ST_SQRT: begin
            cmd.op = ptsl_pkg::ALU_SQRT;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ptsl_pkg::ST_LEN;
            end
         end
         ptsl_pkg::ST_LEN: begin
            cmd.op   = ptsl_pkg::ALU_LEN;
            state_in = ptsl_pkg::ST_CHECK;
         end
         ptsl_pkg::ST_CHECK: begin
            if (phase_ff) begin
               state_in = ptsl_pkg::ST_DONE;
            end else if (step_take) begin
               state_in = ptsl_pkg::ST_MUL_INIT;
            end else begin
               state_in = ptsl_pkg::ST_YAW;
            end
         end
         ptsl_pkg::ST_MUL_INIT: begin
            cmd.op   = ptsl_pkg::ALU_MUL_INIT;
            cnt_in   = CNTW'(ptsl_pkg::TSTEP_W - 1);
            state_in = ptsl_pkg::ST_MUL;
         end
         ptsl_pkg::ST_MUL: begin
            cmd.op = ptsl_pkg::ALU_MUL;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ptsl_pkg::ST_DIV_INIT;
            end
         end
         ptsl_pkg::ST_DIV_INIT: begin
            cmd.op   = ptsl_pkg::ALU_DIV_INIT;
            cnt_in   = CNTW'(MW - 1);
            state_in = ptsl_pkg::ST_DIV;
         end
         ptsl_pkg::ST_DIV: begin
            cmd.op = ptsl_pkg::ALU_DIV;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ptsl_pkg::ST_APPLY;
            end
         end
         ptsl_pkg::ST_APPLY: begin
            state_in = axis_ff ? ptsl_pkg::ST_YAW : ptsl_pkg::ST_MUL_INIT;
         end
         ptsl_pkg::ST_YAW: begin
            state_in = ptsl_pkg::ST_LOAD;
         end
         ptsl_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ptsl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptsl_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tstep_ff <= '0;
         ystep_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ptsl_pkg::CSR_TSTEP: tstep_ff <= csr_wdata[ptsl_pkg::TSTEP_W-1:0];
            ptsl_pkg::CSR_YSTEP: ystep_ff <= csr_wdata[ptsl_pkg::YSTEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // target and pending flag
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff   <= '0;
         ty_ff   <= '0;
         tyaw_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         case (state_ff)
            ptsl_pkg::ST_IDLE: begin
               if (req_fire) begin
                  case (req_ch.opcode)
                     ptsl_pkg::OP_SET: begin
                        tx_ff   <= req_ch.pose_x;
                        ty_ff   <= req_ch.pose_y;
                        tyaw_ff <= req_ch.pose_yaw;
                        pend_ff <= req_ch.pose_valid;
                     end
                     ptsl_pkg::OP_CLEAR: begin
                        tx_ff   <= '0;
                        ty_ff   <= '0;
                        tyaw_ff <= '0;
                        pend_ff <= 1'b0;
                     end
                     ptsl_pkg::OP_BLEND: begin
                        if (pend_ff && !req_ch.pose_valid) begin
                           pend_ff <= 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ptsl_pkg::ST_CHECK: begin
               if (phase_ff && settle) begin
                  pend_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // working pose registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ptsl_pkg::ST_IDLE: begin
            if (req_fire) begin
               cx_ff    <= req_ch.pose_x;
               cy_ff    <= req_ch.pose_y;
               cyaw_ff  <= req_ch.pose_yaw;
               track_ff <= req_ch.tracking;
               phase_ff <= 1'b0;
               if (!pend_ff) begin
                  ox_ff     <= req_ch.pose_x;
                  oy_ff     <= req_ch.pose_y;
                  oyaw_ff   <= req_ch.pose_yaw;
                  ovalid_ff <= req_ch.pose_valid;
               end else begin
                  ox_ff     <= tx_ff;
                  oy_ff     <= ty_ff;
                  oyaw_ff   <= tyaw_ff;
                  ovalid_ff <= 1'b1;
               end
            end
         end
         ptsl_pkg::ST_LOAD: begin
            sx_ff <= dx[CW];
            sy_ff <= dy[CW];
         end
         ptsl_pkg::ST_CHECK: begin
            axis_ff <= 1'b0;
            if (!phase_ff && !step_take) begin
               ox_ff <= tx_ff;
               oy_ff <= ty_ff;
            end
         end
         ptsl_pkg::ST_APPLY: begin
            axis_ff <= 1'b1;
            if (axis_ff) begin
               oy_ff <= app_res;
            end else begin
               ox_ff <= app_res;
            end
         end
         ptsl_pkg::ST_YAW: begin
            oyaw_ff  <= oyaw_new[YW-1:0];
            phase_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ptsl_pkg::ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ptsl_pkg::ST_DONE && rsp_free) begin
         rsp_x_ff      <= ox_ff;
         rsp_y_ff      <= oy_ff;
         rsp_yaw_ff    <= oyaw_ff;
         rsp_ovalid_ff <= ovalid_ff;
         rsp_active_ff <= pend_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.out_x           = rsp_x_ff;
   assign rsp_ch.out_y           = rsp_y_ff;
   assign rsp_ch.out_yaw         = rsp_yaw_ff;
   assign rsp_ch.out_valid       = rsp_ovalid_ff;
   assign rsp_ch.blending_active = rsp_active_ff;

endmodule

// ===== rtl/core/ptsl_arith.sv =====
// shared iterative unit: normalize, square, root, shift-add multiply, restoring divide
module ptsl_arith #(
   parameter int CW = 32
) (
   input  logic                    clock,
   input  ptsl_pkg::alu_cmd_type   cmd,
   input  logic [CW:0]             mag_x_i,
   input  logic [CW:0]             mag_y_i,
   input  logic [ptsl_pkg::TSTEP_W-1:0] step_i,
   output logic                    norm_done_o,
   output logic [((CW+1 > 64) ? 64 : CW+1)-1:0] len_o,
   output logic [CW+ptsl_pkg::TSTEP_W:0] acc_o
);

   localparam int MAGW = CW + 1;
   localparam int LW   = (CW + 1 > 64) ? 64 : CW + 1;
   localparam int MW   = MAGW + ptsl_pkg::TSTEP_W;
   localparam int KW   = $clog2(CW + 2);
   localparam int SW   = (LW + 1 > 34) ? LW + 1 : 34;

   logic [MAGW-1:0]  ax_ff, ay_ff, mx_ff, my_ff;
   logic [KW-1:0]    k_ff;
   logic [63:0]      sq_ff;
   logic [31:0]      root_ff;
   logic [33:0]      srem_ff;
   logic [LW-1:0]    len_ff;
   logic [MW-1:0]    acc_ff;
   logic [ptsl_pkg::TSTEP_W-1:0] sreg_ff;
   logic [LW:0]      drem_ff;

   logic [30:0]      mop;
   logic [61:0]      prod;
   logic [33:0]      trial_rem;
   logic [33:0]      trial;
   logic [LW:0]      drem_sh;
   logic [SW-1:0]    sub_a, sub_b;
   logic [SW:0]      sub_r;
   logic             ge;
   logic [LW+31:0]   len_wide;
   logic [MAGW-1:0]  mcand;

   // one squarer shared by both axes
   assign mop  = (cmd.op == ptsl_pkg::ALU_SQY) ? 31'(ay_ff) : 31'(ax_ff);
   assign prod = mop * mop;

   // one subtractor shared by root and divide
   assign trial_rem = {srem_ff[31:0], sq_ff[63:62]};
   assign trial     = {root_ff, 2'b01};
   assign drem_sh   = {drem_ff[LW-1:0], acc_ff[MW-1]};

   always_comb begin
      if (cmd.op == ptsl_pkg::ALU_SQRT) begin
         sub_a = SW'(trial_rem);
         sub_b = SW'(trial);
      end else begin
         sub_a = SW'(drem_sh);
         sub_b = SW'(len_ff);
      end
      sub_r = {1'b0, sub_a} - {1'b0, sub_b};
      ge    = ~sub_r[SW];
   end

   assign len_wide = (LW+32)'(root_ff) << k_ff;
   assign mcand    = cmd.axis_y ? my_ff : mx_ff;

   // operation step per command
   always_ff @(posedge clock) begin
      case (cmd.op)
         ptsl_pkg::ALU_LOAD: begin
            ax_ff <= mag_x_i;
            ay_ff <= mag_y_i;
            mx_ff <= mag_x_i;
            my_ff <= mag_y_i;
            k_ff  <= '0;
         end
         ptsl_pkg::ALU_NORM: begin
            ax_ff <= ax_ff >> 1;
            ay_ff <= ay_ff >> 1;
            k_ff  <= k_ff + 1'b1;
         end
         ptsl_pkg::ALU_SQX: begin
            sq_ff <= 64'(prod);
         end
         ptsl_pkg::ALU_SQY: begin
            sq_ff <= sq_ff + 64'(prod);
         end
         ptsl_pkg::ALU_SQRT_INIT: begin
            srem_ff <= '0;
            root_ff <= '0;
         end
         ptsl_pkg::ALU_SQRT: begin
            if (ge) begin
               srem_ff <= sub_r[33:0];
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= trial_rem;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            sq_ff <= sq_ff << 2;
         end
         ptsl_pkg::ALU_LEN: begin
            len_ff <= len_wide[LW-1:0];
         end
         ptsl_pkg::ALU_MUL_INIT: begin
            acc_ff  <= '0;
            sreg_ff <= step_i;
         end
         ptsl_pkg::ALU_MUL: begin
            acc_ff  <= (acc_ff << 1) + (sreg_ff[ptsl_pkg::TSTEP_W-1] ? MW'(mcand) : '0);
            sreg_ff <= sreg_ff << 1;
         end
         ptsl_pkg::ALU_DIV_INIT: begin
            drem_ff <= '0;
         end
         ptsl_pkg::ALU_DIV: begin
            acc_ff  <= {acc_ff[MW-2:0], ge};
            drem_ff <= ge ? sub_r[LW:0] : drem_sh;
         end
         default: begin
         end
      endcase
   end

   assign norm_done_o = (((ax_ff | ay_ff) >> 31) == '0);
   assign len_o       = len_ff;
   assign acc_o       = acc_ff;

endmodule
